// ----- rtl/paragraph_line_break_optimizer_top_defines.svh -----
// Assertion helpers used by the optimizer engine RTL.
`ifndef PARAGRAPH_LINE_BREAK_OPTIMIZER_TOP_DEFINES_SVH
`define PARAGRAPH_LINE_BREAK_OPTIMIZER_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define PLBO_ASSERT_IMPL(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define PLBO_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ----- rtl/plbo_pkg.sv -----
package plbo_pkg;

    localparam int POS_W  = 24;
    localparam int IDX_W  = 6;
    localparam int NODE_W = 7;
    localparam int COST_W = 64;
    // working width for line slack; magnitude stays below 2^26
    localparam int D_W    = 28;
    localparam int MAG_W  = D_W - 1;

    localparam logic [COST_W-1:0] COST_INF   = '1;
    localparam logic [NODE_W-1:0] START_NODE = 7'd64;

    // configuration register indexes
    localparam logic [1:0] CFG_START_OFFSET = 2'd0;
    localparam logic [1:0] CFG_IDEAL_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_DH_PENALTY   = 2'd2;

    typedef struct packed {
        logic signed [POS_W-1:0] line_end_x;
        logic signed [POS_W-1:0] next_start_x;
        logic signed [POS_W-1:0] break_penalty;
        logic                    is_hard_break;
        logic                    is_hyphen;
        logic                    last_break;
    } in_item_t;

    typedef struct packed {
        logic [IDX_W-1:0] chosen_break_index;
        logic             last_of_path;
    } out_item_t;

    typedef struct packed {
        logic signed [POS_W-1:0] start_offset;
        logic signed [POS_W-1:0] ideal_line_width;
        logic signed [POS_W-1:0] double_hyphen_penalty;
    } cfg_t;

    // geometry seen from the target end of a line
    typedef struct packed {
        logic signed [POS_W-1:0] line_end_x;
        logic signed [POS_W-1:0] break_penalty;
        logic                    hard;
        logic                    hyphen;
    } geo_t;

    // geometry seen from the source end of a line
    typedef struct packed {
        logic signed [POS_W-1:0] next_start_x;
        logic                    hyphen;
    } src_t;

    // queued load request
    typedef struct packed {
        geo_t geo;
        src_t src;
        logic last_break;
    } ld_item_t;

endpackage

// ----- rtl/plbo_ram.sv -----
module plbo_ram #(
    parameter int WIDTH  = 8,
    parameter int ADDR_W = 6
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);
    localparam int DEPTH = 1 << ADDR_W;

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// ----- rtl/plbo_front.sv -----
module plbo_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  plbo_pkg::in_item_t  in_data,
    output logic                q_valid,
    output plbo_pkg::ld_item_t  q_item,
    input  logic                q_pop
);
    plbo_pkg::ld_item_t slot_reg [2];
    logic               wptr_reg, wptr_next;
    logic               rptr_reg, rptr_next;
    logic [1:0]         fill_reg, fill_next;
    plbo_pkg::ld_item_t cls;
    logic               push;
    logic               pop;

    // split the request into target and source views
    always_comb
    begin
        cls.geo.line_end_x    = in_data.line_end_x;
        cls.geo.break_penalty = in_data.break_penalty;
        cls.geo.hard          = in_data.is_hard_break;
        cls.geo.hyphen        = in_data.is_hyphen;
        cls.src.next_start_x  = in_data.next_start_x;
        cls.src.hyphen        = in_data.is_hyphen;
        cls.last_break        = in_data.last_break;
    end

    assign in_stall = (fill_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign q_valid  = (fill_reg != 2'd0);
    assign pop      = q_pop && q_valid;
    assign q_item   = slot_reg[rptr_reg];

    // two-entry queue pointers
    always_comb
    begin
        wptr_next = push ? !wptr_reg : wptr_reg;
        rptr_next = pop  ? !rptr_reg : rptr_reg;
        fill_next = fill_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            fill_reg <= 2'd0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wptr_reg] <= cls;
        end
    end
endmodule

// ----- rtl/plbo_engine.sv -----
`include "paragraph_line_break_optimizer_top_defines.svh"

module plbo_engine #(
    parameter int MAX_BREAKS = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  plbo_pkg::cfg_t      cfg,
    input  logic                q_valid,
    input  plbo_pkg::ld_item_t  q_item,
    output logic                q_pop,
    output logic                out_valid,
    input  logic                out_stall,
    output plbo_pkg::out_item_t out_data
);
    localparam int IW = plbo_pkg::IDX_W;
    localparam int NW = plbo_pkg::NODE_W;
    localparam int DW = plbo_pkg::D_W;
    localparam int CW = plbo_pkg::COST_W;
    localparam logic [NW-1:0] LAST_SLOT = NW'(MAX_BREAKS - 1);
    localparam logic [NW-1:0] MAX_N     = NW'(MAX_BREAKS);

    typedef enum logic [3:0] {
        S_LOAD, S_UADDR, S_UDATA, S_RADDR, S_RDATA, S_RMUL, S_RUPD, S_REND,
        S_MADDR, S_MDATA, S_BADDR, S_BDATA, S_EADDR, S_EDATA
    } state_t;

    state_t                 state_reg, state_next;
    logic [IW-1:0]          cnt_reg, cnt_next;
    logic [NW-1:0]          count_reg, count_next;
    logic [NW-1:0]          u_reg, u_next;
    logic [CW-1:0]          base_reg, base_next;
    logic signed [DW-1:0]   ls_reg, ls_next;
    logic                   uhy_reg, uhy_next;
    logic [NW-1:0]          v_reg, v_next;
    logic                   found_reg, found_next;
    logic signed [DW-1:0]   d_reg, d_next;
    logic                   hard_reg, hard_next;
    logic [CW-1:0]          w_reg, w_next;
    logic [CW-1:0]          costv_reg, costv_next;
    logic [CW-1:0]          best_reg, best_next;
    logic [IW-1:0]          pick_reg, pick_next;
    logic                   pickf_reg, pickf_next;
    logic [NW-1:0]          i_reg, i_next;
    logic [MAX_BREAKS-1:0]  exam_reg, exam_next;
    logic [MAX_BREAKS-1:0]  cvalid_reg, cvalid_next;
    logic [NW-1:0]          node_reg, node_next;
    logic [NW-1:0]          n_reg, n_next;
    logic                   out_valid_reg, out_valid_next;
    plbo_pkg::out_item_t    out_reg, out_next;

    // memory ports
    logic                    geo_we;
    logic [IW-1:0]           geo_raddr;
    logic [$bits(plbo_pkg::geo_t)-1:0] geo_rdata;
    logic [IW-1:0]           src_raddr;
    logic [$bits(plbo_pkg::src_t)-1:0] src_rdata;
    logic                    cost_we;
    logic [IW-1:0]           cost_waddr, cost_raddr;
    logic [CW-1:0]           cost_wdata, cost_rdata;
    logic [IW-1:0]           pred_raddr;
    logic [NW-1:0]           pred_wdata, pred_rdata;
    logic                    stk_we;
    logic [IW-1:0]           stk_raddr;
    logic [IW-1:0]           stk_rdata;

    plbo_pkg::geo_t          geo;
    plbo_pkg::src_t          src;
    logic                    close;
    logic signed [DW-1:0]    diff;
    logic signed [DW-1:0]    dsum;
    logic [plbo_pkg::MAG_W-1:0] mag;
    logic [CW:0]             sum;
    logic [CW-1:0]           total;
    logic [NW-1:0]           first;
    logic [NW-1:0]           n_dec;

    plbo_ram #(.WIDTH($bits(plbo_pkg::geo_t)), .ADDR_W(IW)) u_geo_ram (
        .clk(clk), .we(geo_we), .waddr(cnt_reg), .wdata(q_item.geo),
        .raddr(geo_raddr), .rdata(geo_rdata)
    );
    plbo_ram #(.WIDTH($bits(plbo_pkg::src_t)), .ADDR_W(IW)) u_src_ram (
        .clk(clk), .we(geo_we), .waddr(cnt_reg), .wdata(q_item.src),
        .raddr(src_raddr), .rdata(src_rdata)
    );
    plbo_ram #(.WIDTH(CW), .ADDR_W(IW)) u_cost_ram (
        .clk(clk), .we(cost_we), .waddr(cost_waddr), .wdata(cost_wdata),
        .raddr(cost_raddr), .rdata(cost_rdata)
    );
    plbo_ram #(.WIDTH(NW), .ADDR_W(IW)) u_pred_ram (
        .clk(clk), .we(cost_we), .waddr(cost_waddr), .wdata(pred_wdata),
        .raddr(pred_raddr), .rdata(pred_rdata)
    );
    plbo_ram #(.WIDTH(IW), .ADDR_W(IW)) u_stk_ram (
        .clk(clk), .we(stk_we), .waddr(n_reg[IW-1:0]), .wdata(node_reg[IW-1:0]),
        .raddr(stk_raddr), .rdata(stk_rdata)
    );

    // datapath terms
    always_comb
    begin
        geo   = plbo_pkg::geo_t'(geo_rdata);
        src   = plbo_pkg::src_t'(src_rdata);
        close = q_item.last_break || ({1'b0, cnt_reg} == LAST_SLOT);
        diff  = DW'(cfg.ideal_line_width) - (DW'(geo.line_end_x) - ls_reg);
        dsum  = diff + DW'(geo.break_penalty);
        if ((u_reg != plbo_pkg::START_NODE) && uhy_reg && geo.hyphen)
        begin
            dsum = dsum + DW'(cfg.double_hyphen_penalty);
        end
        mag   = d_reg[DW-1] ? plbo_pkg::MAG_W'(-d_reg) : plbo_pkg::MAG_W'(d_reg);
        sum   = {1'b0, base_reg} + {1'b0, w_reg};
        total = sum[CW] ? plbo_pkg::COST_INF : sum[CW-1:0];
        first = (u_reg == plbo_pkg::START_NODE) ? '0 : u_reg + NW'(1);
        n_dec = n_reg - NW'(1);
    end

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        count_next  = count_reg;
        u_next      = u_reg;
        base_next   = base_reg;
        ls_next     = ls_reg;
        uhy_next    = uhy_reg;
        v_next      = v_reg;
        found_next  = found_reg;
        d_next      = d_reg;
        hard_next   = hard_reg;
        w_next      = w_reg;
        costv_next  = costv_reg;
        best_next   = best_reg;
        pick_next   = pick_reg;
        pickf_next  = pickf_reg;
        i_next      = i_reg;
        exam_next   = exam_reg;
        cvalid_next = cvalid_reg;
        node_next   = node_reg;
        n_next      = n_reg;
        out_next    = out_reg;
        out_valid_next = out_valid_reg && out_stall;

        q_pop      = 1'b0;
        geo_we     = 1'b0;
        geo_raddr  = v_reg[IW-1:0];
        src_raddr  = u_reg[IW-1:0];
        cost_we    = 1'b0;
        cost_waddr = v_reg[IW-1:0];
        cost_wdata = total;
        pred_wdata = u_reg;
        cost_raddr = v_reg[IW-1:0];
        pred_raddr = node_reg[IW-1:0];
        stk_we     = 1'b0;
        stk_raddr  = n_dec[IW-1:0];

        unique case (state_reg)
            S_LOAD:
            begin
                q_pop = 1'b1;
                if (q_valid)
                begin
                    geo_we = 1'b1;
                    if (close)
                    begin
                        count_next  = {1'b0, cnt_reg} + NW'(1);
                        cnt_next    = '0;
                        cvalid_next = '0;
                        exam_next   = '0;
                        u_next      = plbo_pkg::START_NODE;
                        base_next   = '0;
                        ls_next     = -DW'(cfg.start_offset);
                        uhy_next    = 1'b0;
                        v_next      = '0;
                        found_next  = 1'b0;
                        state_next  = S_RADDR;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + IW'(1);
                    end
                end
            end
            S_UADDR:
            begin
                state_next = S_UDATA;
            end
            S_UDATA:
            begin
                ls_next    = DW'(src.next_start_x);
                uhy_next   = src.hyphen;
                v_next     = u_reg + NW'(1);
                found_next = 1'b0;
                state_next = S_RADDR;
            end
            S_RADDR:
            begin
                state_next = (v_reg < count_reg) ? S_RDATA : S_REND;
            end
            S_RDATA:
            begin
                if (diff[DW-1])
                begin
                    state_next = S_REND;
                end
                else
                begin
                    d_next     = dsum;
                    hard_next  = geo.hard;
                    costv_next = cvalid_reg[v_reg[IW-1:0]] ? cost_rdata
                                                           : plbo_pkg::COST_INF;
                    state_next = S_RMUL;
                end
            end
            S_RMUL:
            begin
                w_next     = hard_reg ? '0 : CW'(mag * mag);
                state_next = S_RUPD;
            end
            S_RUPD:
            begin
                if (total < costv_reg)
                begin
                    cost_we = 1'b1;
                    cvalid_next[v_reg[IW-1:0]] = 1'b1;
                end
                found_next = 1'b1;
                v_next     = v_reg + NW'(1);
                state_next = (w_reg == '0) ? S_REND : S_RADDR;
            end
            S_REND:
            begin
                // nothing reachable: force the next break at equal cost
                if (!found_reg && (first < count_reg))
                begin
                    cost_we    = 1'b1;
                    cost_waddr = first[IW-1:0];
                    cost_wdata = base_reg;
                    cvalid_next[first[IW-1:0]] = 1'b1;
                end
                i_next     = '0;
                best_next  = plbo_pkg::COST_INF;
                pickf_next = 1'b0;
                state_next = S_MADDR;
            end
            S_MADDR:
            begin
                cost_raddr = i_reg[IW-1:0];
                if (i_reg < count_reg)
                begin
                    state_next = S_MDATA;
                end
                else if (pickf_reg)
                begin
                    exam_next[pick_reg] = 1'b1;
                    u_next     = {1'b0, pick_reg};
                    base_next  = best_reg;
                    state_next = S_UADDR;
                end
                else
                begin
                    node_next  = count_reg - NW'(1);
                    n_next     = '0;
                    state_next = S_BADDR;
                end
            end
            S_MDATA:
            begin
                if (!exam_reg[i_reg[IW-1:0]] && cvalid_reg[i_reg[IW-1:0]] &&
                    (cost_rdata < best_reg))
                begin
                    best_next  = cost_rdata;
                    pick_next  = i_reg[IW-1:0];
                    pickf_next = 1'b1;
                end
                i_next     = i_reg + NW'(1);
                state_next = S_MADDR;
            end
            S_BADDR:
            begin
                stk_we     = 1'b1;
                n_next     = n_reg + NW'(1);
                state_next = S_BDATA;
            end
            S_BDATA:
            begin
                node_next = pred_rdata;
                if ((pred_rdata != plbo_pkg::START_NODE) && (pred_rdata < count_reg) &&
                    (n_reg < MAX_N))
                begin
                    state_next = S_BADDR;
                end
                else
                begin
                    state_next = S_EADDR;
                end
            end
            S_EADDR:
            begin
                state_next = S_EDATA;
            end
            S_EDATA:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next              = 1'b1;
                    out_next.chosen_break_index = stk_rdata;
                    out_next.last_of_path       = (n_reg == NW'(1));
                    n_next     = n_dec;
                    state_next = (n_reg == NW'(1)) ? S_LOAD : S_EADDR;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            cnt_reg       <= '0;
            count_reg     <= '0;
            u_reg         <= '0;
            v_reg         <= '0;
            found_reg     <= 1'b0;
            pickf_reg     <= 1'b0;
            i_reg         <= '0;
            exam_reg      <= '0;
            cvalid_reg    <= '0;
            node_reg      <= '0;
            n_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            count_reg     <= count_next;
            u_reg         <= u_next;
            v_reg         <= v_next;
            found_reg     <= found_next;
            pickf_reg     <= pickf_next;
            i_reg         <= i_next;
            exam_reg      <= exam_next;
            cvalid_reg    <= cvalid_next;
            node_reg      <= node_next;
            n_reg         <= n_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        base_reg  <= base_next;
        ls_reg    <= ls_next;
        uhy_reg   <= uhy_next;
        d_reg     <= d_next;
        hard_reg  <= hard_next;
        w_reg     <= w_next;
        costv_reg <= costv_next;
        best_reg  <= best_next;
        pick_reg  <= pick_next;
        out_reg   <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    `PLBO_ASSERT_IMPL(a_slot_range, state_reg == S_LOAD, {1'b0, cnt_reg} <= LAST_SLOT, "load slot past store")
    `PLBO_ASSERT_NEXT(a_search_clear, (state_reg == S_LOAD) && q_valid && close, (exam_reg == '0) && (cvalid_reg == '0), "search started with stale marks")
    `PLBO_ASSERT_IMPL(a_emit_nonempty, (state_reg == S_EADDR) || (state_reg == S_EDATA), n_reg != '0, "emit with empty path")
endmodule

// ----- rtl/paragraph_line_break_optimizer_top.sv -----
// Loading: one break request per cycle via a two-entry queue, stalled while full.
// Search: starts after the last break; relaxing edges and the min scan over nodes
// share the cost RAM read port.
// Emission: path indices leave in path order after a backtrack stacks them.
// Reset: async active-low; clears config to zero, the queue, the load count and flags.
module paragraph_line_break_optimizer_top #(
    parameter int MAX_BREAKS = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [23:0]         cfg_wdata,
    input  logic                in_valid,
    output logic                in_stall,
    input  plbo_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output plbo_pkg::out_item_t out_data
);
    plbo_pkg::cfg_t     cfg_reg;
    logic               q_valid;
    logic               q_pop;
    plbo_pkg::ld_item_t q_item;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                plbo_pkg::CFG_START_OFFSET: cfg_reg.start_offset          <= cfg_wdata;
                plbo_pkg::CFG_IDEAL_WIDTH:  cfg_reg.ideal_line_width      <= cfg_wdata;
                plbo_pkg::CFG_DH_PENALTY:   cfg_reg.double_hyphen_penalty <= cfg_wdata;
                default:
                begin
                end
            endcase
        end
    end

    plbo_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
    );

    plbo_engine #(.MAX_BREAKS(MAX_BREAKS)) u_engine (
        .clk(clk), .rst_n(rst_n), .cfg(cfg_reg),
        .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
    );
endmodule

// ----- sim/paragraph_line_break_optimizer_top_tb.sv -----
`timescale 1ns / 1ps

// Scoreboard: models the break store and the shortest-path search and holds
// the break indices still owed by the block.
class break_path_scoreboard;
    localparam int NB = 64;
    localparam logic [63:0] INF = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam int VSTART = 64;
    localparam int NONE = 255;

    longint start_off, ideal_w, dh_pen;
    int end_x[NB];
    int start_x[NB];
    int pen[NB];
    bit hard[NB];
    bit hyph[NB];
    logic [63:0] cost[NB];
    int pred[NB];
    logic [63:0] done_mask;
    int loaded;

    plbo_pkg::out_item_t pending_breaks[$];
    int mismatches;
    int paragraphs;
    int results_seen;

    function new();
        start_off = 0;
        ideal_w = 0;
        dh_pen = 0;
        loaded = 0;
        mismatches = 0;
        paragraphs = 0;
        results_seen = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic signed [23:0] val);
        if (idx == plbo_pkg::CFG_START_OFFSET)
            start_off = longint'(val);
        else if (idx == plbo_pkg::CFG_IDEAL_WIDTH)
            ideal_w = longint'(val);
        else if (idx == plbo_pkg::CFG_DH_PENALTY)
            dh_pen = longint'(val);
    endfunction

    // Line weight from u to v; returns 0 when the line is too wide.
    function bit line_weight(int u, int v, output logic [63:0] w);
        longint ls, slack, d;
        ls = (u == VSTART) ? -start_off : longint'(start_x[u]);
        slack = ideal_w - (longint'(end_x[v]) - ls);
        w = 0;
        if (slack < 0)
            return 0;
        if (hard[v])
            return 1;
        d = slack + longint'(pen[v]);
        if (u != VSTART && hyph[u] && hyph[v])
            d += dh_pen;
        if (d < 0)
            d = -d;
        w = d * d;
        return 1;
    endfunction

    function void relax(int u, int n);
        logic [63:0] base, w, tot;
        int first;
        bit found;
        base = (u == VSTART) ? 64'd0 : cost[u];
        first = (u == VSTART) ? 0 : u + 1;
        found = 0;
        for (int v = first; v < n; v++)
        begin
            if (!line_weight(u, v, w))
                break;
            tot = (base > INF - w) ? INF : base + w;
            if (cost[v] > tot)
            begin
                cost[v] = tot;
                pred[v] = u;
            end
            found = 1;
            if (w == 0)
                break;
        end
        // dead end: force the next break at equal cost
        if (!found && first < n)
        begin
            cost[first] = base;
            pred[first] = u;
        end
    endfunction

    function int take_cheapest(int n);
        logic [63:0] best;
        int pick;
        best = INF;
        pick = NONE;
        for (int i = 0; i < n; i++)
            if (!done_mask[i] && cost[i] < best)
            begin
                best = cost[i];
                pick = i;
            end
        if (pick != NONE)
            done_mask[pick] = 1'b1;
        return pick;
    endfunction

    // Note an accepted request; solves the paragraph when it closes.
    function void note_request(plbo_pkg::in_item_t it);
        int idx, n, node, len;
        int chain[$];
        plbo_pkg::out_item_t r;
        idx = (loaded >= NB) ? NB - 1 : loaded;
        end_x[idx] = int'(it.line_end_x);
        start_x[idx] = int'(it.next_start_x);
        pen[idx] = int'(it.break_penalty);
        hard[idx] = it.is_hard_break;
        hyph[idx] = it.is_hyphen;
        loaded = idx + 1;
        if (!it.last_break && loaded < NB)
            return;
        n = loaded;
        loaded = 0;
        paragraphs++;
        for (int i = 0; i < NB; i++)
            cost[i] = INF;
        done_mask = '0;
        node = VSTART;
        do
        begin
            relax(node, n);
            node = take_cheapest(n);
        end while (node != NONE);
        node = n - 1;
        while (node != VSTART && node < n && chain.size() < NB)
        begin
            chain.push_front(node);
            node = pred[node];
        end
        len = chain.size();
        for (int i = 0; i < len; i++)
        begin
            r.chosen_break_index = chain[i][5:0];
            r.last_of_path = (i == len - 1);
            pending_breaks.push_back(r);
        end
    endfunction

    function void check_result(plbo_pkg::out_item_t got);
        plbo_pkg::out_item_t exp_r;
        results_seen++;
        if (pending_breaks.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result idx=%0d last=%0d",
                         got.chosen_break_index, got.last_of_path);
            return;
        end
        exp_r = pending_breaks.pop_front();
        if (got.chosen_break_index !== exp_r.chosen_break_index ||
            got.last_of_path !== exp_r.last_of_path)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: exp idx=%0d last=%0d, got idx=%0d last=%0d",
                         exp_r.chosen_break_index, exp_r.last_of_path,
                         got.chosen_break_index, got.last_of_path);
        end
    endfunction
endclass

module paragraph_line_break_optimizer_top_tb;

    localparam int WATCHDOG_LIMIT = 200000;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [1:0] cfg_index;
    logic [23:0] cfg_wdata;
    logic in_valid;
    logic in_stall;
    plbo_pkg::in_item_t in_data;
    logic out_valid;
    logic out_stall;
    plbo_pkg::out_item_t out_data;

    break_path_scoreboard sb;
    bit quiet_phase;
    bit hold_receiver;
    int idle_cycles;
    int requests_sent;

    paragraph_line_break_optimizer_top u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data(out_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Receiver: random stalls, none in the quiet phase, long hold on request
    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_receiver)
            out_stall <= 1'b1;
        else
            out_stall <= !quiet_phase && ($urandom_range(99) < 11);
    end

    // Check results and watch for a hang
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                sb.check_result(out_data);
            if ((out_valid && !out_stall) || (in_valid && !in_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog expired");
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        sb.set_reg(idx, val);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_regs(input logic [23:0] so, input logic [23:0] iw,
                            input logic [23:0] dh);
        write_reg(plbo_pkg::CFG_START_OFFSET, so);
        write_reg(plbo_pkg::CFG_IDEAL_WIDTH, iw);
        write_reg(plbo_pkg::CFG_DH_PENALTY, dh);
    endtask

    // Present one request and hold it until accepted; valid stays up after
    // acceptance so the next request can follow without a gap
    task automatic send_break(input plbo_pkg::in_item_t it);
        while (!quiet_phase && $urandom_range(99) < 11)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_request(it);
        requests_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending_breaks.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    function automatic plbo_pkg::in_item_t make_break(int x0, int sx, int pn, bit h,
                                                      bit y, bit lst);
        plbo_pkg::in_item_t it;
        it.line_end_x = 24'(x0);
        it.next_start_x = 24'(sx);
        it.break_penalty = 24'(pn);
        it.is_hard_break = h;
        it.is_hyphen = y;
        it.last_break = lst;
        return it;
    endfunction

    // Mostly well-formed paragraph: positions grow along the text, with an occasional random line end
    task automatic send_paragraph(input int n, input int wmax);
        int pos;
        int w;
        plbo_pkg::in_item_t it;
        pos = 0;
        for (int i = 0; i < n; i++)
        begin
            w = int'($urandom_range(wmax, 1));
            pos += w;
            it = make_break(pos, pos + int'($urandom_range(512)),
                            int'($urandom_range(1024)) - 512,
                            $urandom_range(99) < 8, $urandom_range(99) < 25,
                            i == n - 1);
            if ($urandom_range(99) < 5)
                it.line_end_x = 24'($urandom);
            send_break(it);
        end
    endtask

    // Noise: fully random fields
    task automatic send_noise(input int n);
        plbo_pkg::in_item_t it;
        for (int i = 0; i < n; i++)
        begin
            it.line_end_x = 24'($urandom);
            it.next_start_x = 24'($urandom);
            it.break_penalty = 24'($urandom);
            it.is_hard_break = 1'($urandom);
            it.is_hyphen = 1'($urandom);
            it.last_break = (i == n - 1);
            send_break(it);
        end
    endtask

    initial
    begin
        int paragraphs_done;
        sb = new();
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = plbo_pkg::CFG_START_OFFSET;
        cfg_wdata = '0;
        in_valid = 1'b0;
        in_data = '0;
        quiet_phase = 1'b0;
        hold_receiver = 1'b0;
        idle_cycles = 0;
        requests_sent = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed: reset config, single break, extremes, hard and hyphen cases
        send_break(make_break(0, 0, 0, 0, 0, 1));
        drain();
        set_regs(24'd256, 24'd2560, 24'd512);
        send_break(make_break(24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF, 0, 0, 0));
        send_break(make_break(24'sh800000, 24'sh7FFFFF, 24'sh800000, 0, 1, 0));
        send_break(make_break(1000, 1100, 0, 0, 1, 0));
        send_break(make_break(1200, 1250, -300, 0, 1, 0));
        send_break(make_break(2000, 2100, 100, 1, 0, 0));
        send_break(make_break(2100, 2100, 0, 1, 1, 0));
        send_break(make_break(9000, 9100, 0, 0, 0, 0));
        send_break(make_break(4000, 4000, 0, 0, 0, 1));
        drain();
        set_regs(24'h800000, 24'h7FFFFF, 24'h7FFFFF);
        send_break(make_break(24'sh7FFFFF, 0, 24'sh7FFFFF, 0, 1, 0));
        send_break(make_break(24'sh7FFFFF, 0, 24'sh800000, 0, 1, 1));
        drain();
        set_regs(24'h7FFFFF, 24'h800000, 24'h800000);
        send_break(make_break(5, 5, 5, 0, 0, 0));
        send_break(make_break(6, 6, 6, 0, 0, 1));
        drain();

        // Full store closes the paragraph without the last flag
        set_regs(24'd0, 24'd3000, 24'd200);
        quiet_phase = 1'b1;
        begin
            int pos;
            pos = 0;
            for (int i = 0; i < 64; i++)
            begin
                pos += int'($urandom_range(900, 100));
                send_break(make_break(pos, pos + 64, 0, 0, i % 3 == 0, 0));
            end
        end
        quiet_phase = 1'b0;
        drain();

        // Receiver held off while requests keep coming
        fork
            begin
                hold_receiver = 1'b1;
                repeat (3000) @(posedge clk);
                hold_receiver = 1'b0;
            end
            begin
                send_paragraph(6, 700);
                send_paragraph(5, 700);
                send_paragraph(4, 700);
                in_valid <= 1'b0;
                @(posedge clk);
            end
        join
        drain();

        // Random paragraphs under several register settings
        paragraphs_done = 0;
        while (requests_sent < 320)
        begin
            if (paragraphs_done % 6 == 0)
            begin
                drain();
                set_regs(24'($urandom_range(1024)), 24'($urandom_range(6000, 500)),
                         24'(int'($urandom_range(2048)) - 1024));
            end
            quiet_phase = (paragraphs_done % 10) >= 7;
            if ($urandom_range(99) < 15)
                send_noise(int'($urandom_range(6, 1)));
            else
                send_paragraph(int'($urandom_range(12, 1)),
                               int'($urandom_range(1500, 50)));
            paragraphs_done++;
        end
        quiet_phase = 1'b0;
        drain();

        $display("covered %0d breaks in %0d paragraphs, %0d path indices checked",
                 requests_sent, sb.paragraphs, sb.results_seen);
        if (sb.mismatches == 0 && sb.pending_breaks.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
